// ===== hdl/sis_pkg.sv =====
// Shared widths, codes, types and compare helpers for the sorted insert stack.
package sis_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic add_en;  // write a new word into the row
    logic pop_en;  // shift the row toward the top
    logic push;    // new word lands on top
    logic ins;     // new word lands at its sorted place
  } sis_op_t;

  function automatic logic le_s(input word_t a, input word_t b);
    return a <= b;
  endfunction

  function automatic logic lt_s(input word_t a, input word_t b);
    return a < b;
  endfunction

endpackage

// ===== hdl/sis_cell.sv =====
// One stack cell: holds the word at a fixed depth and trades it with its neighbors.
module sis_cell import sis_pkg::*; (
  input  logic    clk,
  input  sis_op_t op,
  input  logic    is_top,
  input  word_t   value,
  input  word_t   up_entry,
  input  logic    up_live,
  input  logic    sel_in,
  input  logic    live,
  input  word_t   down_entry,
  output word_t   entry,
  output logic    sel_out,
  output logic    ordered
);

  logic hit;
  logic v_le_e;
  logic u_le_v;
  logic u_le_e;

  assign v_le_e = le_s(value, entry);
  assign u_le_v = le_s(up_entry, value);
  assign u_le_e = le_s(up_entry, entry);

  // Decide whether the new word lands exactly here
  always_comb begin
    hit = 1'b0;
    if (op.push) begin
      hit = is_top;
    end else if (op.ins) begin
      if (is_top) begin
        hit = !live || lt_s(value, entry);
      end else begin
        hit = up_live && (!live || (u_le_v && v_le_e));
      end
    end
  end

  // Insertion point at or above this depth
  assign sel_out = sel_in || hit;

  // Order check against the cell above
  assign ordered = is_top || !live || u_le_e;

  // Shift, load or hold the stored word
  always_ff @(posedge clk) begin
    if (op.pop_en) begin
      entry <= down_entry;
    end else if (op.add_en) begin
      if (sel_in) begin
        entry <= up_entry;
      end else if (hit) begin
        entry <= value;
      end
    end
  end

endmodule

// ===== hdl/sorted_insert_stack_core.sv =====
// Top level of the sorted insert stack: command decode, cell row and result pipeline.
//
// Usage:
//   Commands arrive on the s_ stream: s_tuser carries the operation (push,
//   pop, sorted insert; the unused code does nothing) and s_tdata the word.
//   Every accepted command yields exactly one result on the m_ stream:
//   popped word, entry count after the operation and the sorted flag in
//   m_tdata, the status code in m_tuser.
//   Each result passes through the middle stage and the output register
//   before m_tvalid. One command is taken every cycle unless the output
//   stalls; the figure is set by the row of cells, where each cell compares
//   the new word with its own and its upper neighbor's word, and the insertion
//   point ripples down the row in the same cycle. The sorted flag comes from
//   the updated row as the result leaves the middle stage and the next command enters.
//   Reset empties the stack (the count goes to zero; stored words are left
//   as they are) and drops any result in flight.
//   When the receiver stalls, the result is held in the output register and
//   one more result waits in the stage before it; after that s_tready drops
//   and the stack holds its contents until the output drains.
module sorted_insert_stack_core import sis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] popped_value, [36:32] entry_count,
                                 // [37] is_sorted, [39:38] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             p1_valid;
  word_t            p1_popped;
  status_t          p1_status;
  logic [CNT_W-1:0] p1_count;

  word_t            out_popped;
  logic [COUNT_W-1:0] out_count;
  logic             out_sorted;

  logic             accept;
  logic             p1_adv;
  logic             full;
  logic             empty;
  mode_t            mode;
  word_t            value;
  sis_op_t          op;
  status_t          status_next;
  word_t            popped_next;
  logic             sorted_all;

  word_t            entries [DEPTH];
  logic [DEPTH-1:0] live;
  logic [DEPTH:0]   sel;
  logic [DEPTH-1:0] ordered;

  assign mode  = mode_t'(s_tuser);
  assign value = word_t'(s_tdata);
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Take a command when the middle stage is free or moving on
  assign p1_adv   = p1_valid && (!m_tvalid || m_tready);
  assign s_tready = !p1_valid || p1_adv;
  assign accept   = s_tvalid && s_tready;

  // Decode the command into the row controls and the result fields
  always_comb begin
    op          = '0;
    status_next = ST_OK;
    popped_next = '0;
    count_next  = count;
    case (mode)
      MODE_PUSH, MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op.add_en  = accept;
          op.push    = (mode == MODE_PUSH);
          op.ins     = (mode == MODE_INSERT);
          count_next = count + 1'b1;
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          op.pop_en   = accept;
          popped_next = entries[0];
          count_next  = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Row of cells, top of the stack at index zero
  assign sel[0] = 1'b0;

  for (genvar d = 0; d < DEPTH; d++) begin : g_cell
    word_t up_e;
    word_t down_e;
    logic  up_l;

    assign live[d] = (CNT_W'(d) < count);

    if (d == 0) begin : g_top
      assign up_e = value;
      assign up_l = 1'b1;
    end else begin : g_mid
      assign up_e = entries[d-1];
      assign up_l = live[d-1];
    end

    if (d == DEPTH - 1) begin : g_bot
      assign down_e = entries[d];
    end else begin : g_up
      assign down_e = entries[d+1];
    end

    sis_cell u_cell (
      .clk        (clk),
      .op         (op),
      .is_top     (d == 0),
      .value      (value),
      .up_entry   (up_e),
      .up_live    (up_l),
      .sel_in     (sel[d]),
      .live       (live[d]),
      .down_entry (down_e),
      .entry      (entries[d]),
      .sel_out    (sel[d+1]),
      .ordered    (ordered[d])
    );
  end

  assign sorted_all = &ordered;

  // Advance the fill count on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Hold the result of the last command until the row settles
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
    if (accept) begin
      p1_popped <= popped_next;
      p1_status <= status_next;
      p1_count  <= count_next;
    end
  end

  // Output register: attach the sorted flag of the settled row
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (p1_adv) begin
      out_popped <= p1_popped;
      out_count  <= COUNT_W'(p1_count);
      out_sorted <= sorted_all;
      m_tuser    <= p1_status;
    end
  end

  assign m_tdata = {2'b00, out_sorted, out_count, out_popped};

endmodule

// ===== tb/sorted_insert_stack_core_test.sv =====
// Self-checking bench for the sorted insert stack core: stream driver, result monitor, shadow stack.
module sorted_insert_stack_core_test import sis_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int CALM_START     = 1000;
  localparam int CALM_END       = 1400;

  typedef struct {
    mode_t mode;
    word_t value;
  } stack_cmd_t;

  typedef struct {
    word_t          popped;
    logic [COUNT_W-1:0] count;
    logic           sorted;
    status_t        status;
  } stack_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] popped_value, [36:32] entry_count,
                               // [37] is_sorted, [39:38] zero
  logic [1:0]  m_tuser;        // [1:0] status

  sorted_insert_stack_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the stack, index 0 is the bottom
  word_t       shadow_stack [DEPTH];
  int unsigned shadow_level = 0;

  stack_cmd_t    cmd_queue[$];
  stack_result_t result_queue[$];
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   cyc = 0;
  bit            cmd_fire = 1'b0;
  word_t         last_value = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow stack and work out the result it yields
  task automatic apply_stack_op(input stack_cmd_t cmd, output stack_result_t res);
    int unsigned slot;
    int          k;
    bit          found;
    word_t       above;
    res.popped = '0;
    res.status = ST_OK;
    if (cmd.mode == MODE_PUSH || cmd.mode == MODE_INSERT) begin
      if (shadow_level >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = shadow_level;
        if (cmd.mode == MODE_INSERT && shadow_level != 0) begin
          above = shadow_stack[shadow_level-1];
          if (!(cmd.value < above)) begin
            // scan down for the first gap that brackets the word, else bottom
            slot  = 0;
            found = 1'b0;
            for (k = shadow_level - 1; k > 0 && !found; k--) begin
              if (above <= cmd.value && cmd.value <= shadow_stack[k-1]) begin
                slot  = k;
                found = 1'b1;
              end else begin
                above = shadow_stack[k-1];
              end
            end
          end
        end
        for (k = shadow_level; k > slot; k--)
          shadow_stack[k] = shadow_stack[k-1];
        shadow_stack[slot] = cmd.value;
        shadow_level++;
      end
    end else if (cmd.mode == MODE_POP) begin
      if (shadow_level == 0) begin
        res.status = ST_EMPTY;
      end else begin
        shadow_level--;
        res.popped = shadow_stack[shadow_level];
      end
    end
    res.count  = shadow_level[COUNT_W-1:0];
    res.sorted = 1'b1;
    for (k = 1; k < shadow_level; k++)
      if (shadow_stack[k-1] < shadow_stack[k]) res.sorted = 1'b0;
  endtask

  // Idle draw for either side; none inside the calm window
  function automatic bit take_break();
    if (cyc >= CALM_START && cyc < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 18;
  endfunction

  function automatic word_t pick_value(input word_t prev);
    word_t v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      2, 3: v = $signed($urandom_range(0, 16)) - 8;
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sh8000_0001;
          3: v = 32'sh7fff_fffe;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: v = prev + ($signed($urandom_range(0, 40)) - 20);
    endcase
    return v;
  endfunction

  task automatic queue_cmd(input mode_t mode, input word_t value);
    stack_cmd_t cmd;
    cmd.mode  = mode;
    cmd.value = value;
    cmd_queue.push_back(cmd);
  endtask

  // Drive commands at the falling edge; hold a command until it transfers
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !take_break();
      if (!s_tvalid || cmd_fire) begin
        if (cmd_queue.size() > 0 && !take_break()) begin
          s_tvalid <= 1'b1;
          s_tuser  <= cmd_queue[0].mode;
          s_tdata  <= cmd_queue[0].value;
        end else begin
          s_tvalid <= 1'b0;
          s_tuser  <= mode_t'($urandom_range(0, 3));
          s_tdata  <= $urandom;
        end
      end
    end
  end

  // Sample both streams at the rising edge: predict on input, check on output
  always @(posedge clk) begin
    stack_result_t exp_res;
    stack_cmd_t    cmd;
    cmd_fire = 1'b0;
    if (!rst) begin
      cyc++;
      quiet_cycles++;
      if (s_tvalid && s_tready) begin
        cmd_fire = 1'b1;
        quiet_cycles = 0;
        cmd = cmd_queue.pop_front();
        apply_stack_op(cmd, exp_res);
        result_queue.push_back(exp_res);
      end
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        if (result_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                   $time, m_tdata, m_tuser);
        end else begin
          exp_res = result_queue.pop_front();
          if ($signed(m_tdata[31:0]) !== exp_res.popped) begin
            mismatches++;
            $display("%0t: popped_value expected %0d got %0d",
                     $time, exp_res.popped, $signed(m_tdata[31:0]));
          end
          if (m_tdata[36:32] !== exp_res.count) begin
            mismatches++;
            $display("%0t: entry_count expected %0d got %0d",
                     $time, exp_res.count, m_tdata[36:32]);
          end
          if (m_tdata[37] !== exp_res.sorted) begin
            mismatches++;
            $display("%0t: is_sorted expected %0b got %0b",
                     $time, exp_res.sorted, m_tdata[37]);
          end
          if (m_tuser !== exp_res.status) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d", $time, exp_res.status, m_tuser);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d commands and %0d results outstanding",
                 $time, cmd_queue.size(), result_queue.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Build the stimulus, release reset and wait for the stream to drain
  initial begin
    int unsigned total;
    int unsigned phase_len;
    int unsigned add_pct;
    int unsigned pop_pct;
    int unsigned r;
    word_t       v;

    // directed: empty stack corners, every operation, top, middle and bottom inserts
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_NOP,    32'sh7fff_ffff);
    queue_cmd(MODE_INSERT, 32'sh7fff_ffff);
    queue_cmd(MODE_INSERT, 32'sh8000_0000);
    queue_cmd(MODE_INSERT, 32'sd0);
    queue_cmd(MODE_INSERT, 32'sd0);
    queue_cmd(MODE_PUSH,   -32'sd1);
    queue_cmd(MODE_NOP,    32'sd0);
    queue_cmd(MODE_POP,    32'sh7fff_ffff);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_PUSH,   32'sd5);
    queue_cmd(MODE_PUSH,   32'sd10);
    queue_cmd(MODE_INSERT, 32'sd7);
    queue_cmd(MODE_INSERT, 32'sd10);
    queue_cmd(MODE_INSERT, 32'sd3);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);
    queue_cmd(MODE_POP,    32'sd0);

    // random phases: fill-heavy, drain-heavy and balanced runs; the first one fills
    total = 0;
    add_pct = 100;
    pop_pct = 0;
    phase_len = 24;
    while (total < RANDOM_ITEMS) begin
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        v = pick_value(last_value);
        last_value = v;
        if (r < add_pct) begin
          // mostly sorted inserts so ordered stacks build up; pushes break order
          if ($urandom_range(0, 99) < 70) queue_cmd(MODE_INSERT, v);
          else queue_cmd(MODE_PUSH, v);
        end else if (r < add_pct + pop_pct) begin
          queue_cmd(MODE_POP, v);
        end else begin
          queue_cmd(MODE_NOP, v);
        end
        total++;
      end
      case ($urandom_range(0, 2))
        0: begin add_pct = 80; pop_pct = 17; end
        1: begin add_pct = 22; pop_pct = 75; end
        default: begin add_pct = 50; pop_pct = 47; end
      endcase
      phase_len = $urandom_range(10, 60);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || result_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
